// ===== rtl/pressure_to_altitude_isa_defines.svh =====
// Assertion macros shared by the pressure-to-altitude RTL.
`ifndef PRESSURE_TO_ALTITUDE_ISA_DEFINES_SVH
`define PRESSURE_TO_ALTITUDE_ISA_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define P2A_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define P2A_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/p2a_pkg.sv =====
// Types, widths and per-layer constants of the pressure-to-altitude datapath.
`timescale 1ns / 1ps
`default_nettype none
package p2a_pkg;

	localparam int PRESS_W = 17;
	localparam int ALT_W   = 23;
	localparam int LAYER_W = 3;
	localparam int NLAYER  = 7;

	localparam int PROD_W = 34;  // pressure * 1e5
	localparam int LOG_W  = 36;  // log2 with Q30 fraction
	localparam int DMAG_W = 33;  // |log2 ratio|, below 8.0
	localparam int CMAG_W = 28;
	localparam int A16_W  = 29;
	localparam int KMAG_W = 34;
	localparam int W_W    = 31;  // exponent, Q30, at most 1.0
	localparam int E_W    = 32;  // exp value, Q30, below 3.0
	localparam int PM_W   = 31;
	localparam int ACC_W  = 40;  // altitude accumulator, Q16 metres

	typedef logic [PRESS_W-1:0]       pressure_t;
	typedef logic signed [ALT_W-1:0]  altitude_t;
	typedef logic [LAYER_W-1:0]       layer_t;

	localparam layer_t LAYER0 = 3'd0;
	localparam layer_t LAYER1 = 3'd1;
	localparam layer_t LAYER2 = 3'd2;
	localparam layer_t LAYER3 = 3'd3;
	localparam layer_t LAYER4 = 3'd4;
	localparam layer_t LAYER5 = 3'd5;
	localparam layer_t LAYER6 = 3'd6;

	localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
	localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

	// layer thresholds: floors of the base pressures in whole pascals
	localparam pressure_t FLOOR1 = 17'd22632;
	localparam pressure_t FLOOR2 = 17'd5474;
	localparam pressure_t FLOOR3 = 17'd868;
	localparam pressure_t FLOOR4 = 17'd110;
	localparam pressure_t FLOOR5 = 17'd66;
	localparam pressure_t FLOOR6 = 17'd3;

	localparam logic [16:0] BASE_H_M [NLAYER] = '{17'd0, 17'd11000, 17'd20000, 17'd32000,
		17'd47000, 17'd51000, 17'd71000};

	// bit i set: layer i has a negative lapse rate / is isothermal
	localparam logic [NLAYER-1:0] LAPSE_NEG = 7'b110_0001;
	localparam logic [NLAYER-1:0] LAYER_ISO = 7'b001_0010;

	// squaring log2, Q30 fraction, every square truncated
	function automatic logic [LOG_W-1:0] log2_q30(input logic [63:0] v);
		logic [5:0]       n;
		logic [63:0]      y;
		logic [63:0]      sq;
		logic [LOG_W-1:0] r;
		n = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 6'(i);
		end
		if (n >= 6'd30) y = v >> (n - 6'd30);
		else y = v << (6'd30 - n);
		r = {n, 30'b0};
		for (int i = 29; i >= 0; i--) begin
			sq = (y * y) >> 30;
			if (sq >= (64'd1 << 31)) begin
				sq = sq >> 1;
				r[i] = 1'b1;
			end
			y = sq;
		end
		return r;
	endfunction

	localparam logic [LOG_W-1:0] LP_Q30 [NLAYER] = '{
		log2_q30(64'd10132500000), log2_q30(64'd2263200000), log2_q30(64'd547489000),
		log2_q30(64'd86801900), log2_q30(64'd11090600), log2_q30(64'd6693880),
		log2_q30(64'd395642)};

	// exponent coefficient |L|*R/g0*ln2, Q30
	localparam logic [63:0] CDEN = 64'd98066500;
	localparam logic [63:0] C65 = (64'd65 * 64'd287053 * 64'd744261118 + CDEN / 2) / CDEN;
	localparam logic [63:0] C10 = (64'd10 * 64'd287053 * 64'd744261118 + CDEN / 2) / CDEN;
	localparam logic [63:0] C28 = (64'd28 * 64'd287053 * 64'd744261118 + CDEN / 2) / CDEN;
	localparam logic [63:0] C20 = (64'd20 * 64'd287053 * 64'd744261118 + CDEN / 2) / CDEN;
	localparam logic [CMAG_W-1:0] CMAG [NLAYER] = '{C65[CMAG_W-1:0], '0, C10[CMAG_W-1:0],
		C28[CMAG_W-1:0], '0, C28[CMAG_W-1:0], C20[CMAG_W-1:0]};

	// isothermal scale R*T/g0*ln2, Q16 metres per Q30 of log2 ratio
	localparam logic [63:0] ADEN = 64'd980665 << 14;
	localparam logic [63:0] A1 = (64'd287053 * 64'd21665 * 64'd744261118 + ADEN / 2) / ADEN;
	localparam logic [63:0] A4 = (64'd287053 * 64'd27065 * 64'd744261118 + ADEN / 2) / ADEN;
	localparam logic [A16_W-1:0] A16 [NLAYER] = '{'0, A1[A16_W-1:0], '0, '0,
		A4[A16_W-1:0], '0, '0};

	// T/|L|, Q16 metres
	localparam logic [63:0] K0 = (64'd28815 * 64'd6553600 + 64'd32) / 64'd65;
	localparam logic [63:0] K2 = (64'd21665 * 64'd6553600 + 64'd5) / 64'd10;
	localparam logic [63:0] K3 = (64'd22865 * 64'd6553600 + 64'd14) / 64'd28;
	localparam logic [63:0] K5 = (64'd27065 * 64'd6553600 + 64'd14) / 64'd28;
	localparam logic [63:0] K6 = (64'd21465 * 64'd6553600 + 64'd10) / 64'd20;
	localparam logic [KMAG_W-1:0] KMAG [NLAYER] = '{K0[KMAG_W-1:0], '0, K2[KMAG_W-1:0],
		K3[KMAG_W-1:0], '0, K5[KMAG_W-1:0], K6[KMAG_W-1:0]};

endpackage
`default_nettype wire

// ===== rtl/p2a_ifs.sv =====
// Valid/ready channel interfaces for pressure samples and altitude results.
`timescale 1ns / 1ps
`default_nettype none
interface p2a_in_if;
	import p2a_pkg::*;
	logic      valid;
	logic      ready;
	pressure_t pressure_pa;
	modport source (output valid, output pressure_pa, input ready);
	modport sink (input valid, input pressure_pa, output ready);
endinterface

interface p2a_out_if;
	import p2a_pkg::*;
	logic      valid;
	logic      ready;
	altitude_t altitude_fixed;
	layer_t    layer_used;
	modport source (output valid, output altitude_fixed, output layer_used, input ready);
	modport sink (input valid, input altitude_fixed, input layer_used, output ready);
endinterface
`default_nettype wire

// ===== rtl/p2a_log2.sv =====
// Pipelined squaring log2: normalize, then one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module p2a_log2 #(
	parameter int SIDE_W = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        vld_in,
	input  wire logic [p2a_pkg::PROD_W-1:0]  val_in,
	input  wire logic [SIDE_W-1:0]           side_in,
	output logic                             vld_out,
	output logic [p2a_pkg::LOG_W-1:0]        log_out,
	output logic [SIDE_W-1:0]                side_out
);
	import p2a_pkg::*;

	localparam int NSQ = 30;

	logic [PROD_W-1:0] v_s1;
	logic [5:0]        n_s1;
	logic              vld_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [5:0]        n_c;
	logic [63:0]       ext_c;
	logic [63:0]       shf_c;

	logic [W_W-1:0]    y_s    [0:NSQ];
	logic [LOG_W-1:0]  r_s    [0:NSQ];
	logic              vld_s  [0:NSQ];
	logic [SIDE_W-1:0] side_s [0:NSQ];

	// leading-one position
	always_comb begin
		n_c = 6'd0;
		for (int i = 0; i < PROD_W; i++) begin
			if (val_in[i]) n_c = 6'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1    <= val_in;
			n_s1    <= n_c;
			side_s1 <= side_in;
		end
	end

	// normalize the mantissa into [1.0, 2.0) in Q30
	always_comb begin
		ext_c = {{(64 - PROD_W){1'b0}}, v_s1};
		if (n_s1 >= 6'd30) shf_c = ext_c >> (n_s1 - 6'd30);
		else shf_c = ext_c << (6'd30 - n_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (adv) vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s[0]    <= shf_c[W_W-1:0];
			r_s[0]    <= {n_s1, 30'b0};
			side_s[0] <= side_s1;
		end
	end

	// one squaring per stage
	for (genvar k = 1; k <= NSQ; k++) begin : g_sq
		localparam int BITPOS = NSQ - k;
		logic [61:0] sq;
		logic [31:0] sh;
		assign sq = 62'(y_s[k-1]) * 62'(y_s[k-1]);
		assign sh = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (adv) vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
				if (sh[31]) begin
					y_s[k] <= sh[31:1];
					r_s[k] <= r_s[k-1] | (LOG_W'(1) << BITPOS);
				end else begin
					y_s[k] <= sh[W_W-1:0];
					r_s[k] <= r_s[k-1];
				end
			end
		end
	end

	assign vld_out  = vld_s[NSQ];
	assign log_out  = r_s[NSQ];
	assign side_out = side_s[NSQ];

endmodule
`default_nettype wire

// ===== rtl/p2a_exp.sv =====
// Pipelined exp (20-term Taylor sum) followed by a restoring reciprocal.
`timescale 1ns / 1ps
`default_nettype none
module p2a_exp #(
	parameter int SIDE_W = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      vld_in,
	input  wire logic [p2a_pkg::W_W-1:0]   w_in,
	input  wire logic                      wneg_in,
	input  wire logic [SIDE_W-1:0]         side_in,
	output logic                           vld_out,
	output logic [p2a_pkg::E_W-1:0]        pw_out,
	output logic [SIDE_W-1:0]              side_out
);
	import p2a_pkg::*;

	localparam int NT = 20;
	localparam int NQ = 31;

	// term stages (after divide by k)
	logic [W_W-1:0]    trm_s  [0:NT];
	logic [E_W-1:0]    sum_s  [0:NT];
	logic [W_W-1:0]    w_s    [0:NT];
	logic              wn_s   [0:NT];
	logic              vld_s  [0:NT];
	logic [SIDE_W-1:0] side_s [0:NT];
	// product stages (term * w)
	logic [W_W-1:0]    a_m    [1:NT];
	logic [E_W-1:0]    sum_m  [1:NT];
	logic [W_W-1:0]    w_m    [1:NT];
	logic              wn_m   [1:NT];
	logic              vld_m  [1:NT];
	logic [SIDE_W-1:0] side_m [1:NT];
	// reciprocal stages
	logic [E_W-1:0]    e_d    [0:NQ];
	logic [E_W-1:0]    rem_d  [0:NQ];
	logic [NQ-1:0]     nlo_d  [0:NQ];
	logic [NQ-1:0]     q_d    [0:NQ];
	logic              wn_d   [0:NQ];
	logic              vld_d  [0:NQ];
	logic [SIDE_W-1:0] side_d [0:NQ];

	logic [E_W-1:0]    pw_s;
	logic              vld_o_s;
	logic [SIDE_W-1:0] side_o_s;

	// series start: term and sum are 1.0
	always_comb begin
		trm_s[0]  = ONE_Q30[W_W-1:0];
		sum_s[0]  = ONE_Q30[E_W-1:0];
		w_s[0]    = w_in;
		wn_s[0]   = wneg_in;
		vld_s[0]  = vld_in;
		side_s[0] = side_in;
	end

	for (genvar k = 1; k <= NT; k++) begin : g_term
		localparam int          LK = $clog2(k);
		localparam int          SK = 31 + LK;
		localparam logic [63:0] MK = ((64'd1 << SK) + 64'(k) - 64'd1) / 64'(k);
		logic [61:0] prod;
		logic [71:0] rprod;
		logic [W_W-1:0] q;

		// term * w, truncated to Q30
		assign prod = 62'(trm_s[k-1]) * 62'(w_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_m[k] <= 1'b0;
			else if (adv) vld_m[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				a_m[k]    <= prod[60:30];
				sum_m[k]  <= sum_s[k-1];
				w_m[k]    <= w_s[k-1];
				wn_m[k]   <= wn_s[k-1];
				side_m[k] <= side_s[k-1];
			end
		end

		// floor divide by k through an exact reciprocal
		assign rprod = 72'(a_m[k]) * 72'(MK[32:0]);
		assign q     = rprod[SK+W_W-1:SK];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (adv) vld_s[k] <= vld_m[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				trm_s[k]  <= q;
				sum_s[k]  <= sum_m[k] + E_W'(q);
				w_s[k]    <= w_m[k];
				wn_s[k]   <= wn_m[k];
				side_s[k] <= side_m[k];
			end
		end
	end

	// 2^60 / e, rounded: long division of 2^60 + e/2 by e
	always_comb begin
		e_d[0]    = sum_s[NT];
		rem_d[0]  = E_W'(HALF_Q30);
		nlo_d[0]  = sum_s[NT][E_W-1:1];
		q_d[0]    = '0;
		wn_d[0]   = wn_s[NT];
		vld_d[0]  = vld_s[NT];
		side_d[0] = side_s[NT];
	end

	for (genvar j = 1; j <= NQ; j++) begin : g_div
		localparam int BITPOS = NQ - j;
		logic [E_W:0] r2;
		logic         ge;
		assign r2 = {rem_d[j-1], nlo_d[j-1][BITPOS]};
		assign ge = r2 >= {1'b0, e_d[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[j] <= 1'b0;
			else if (adv) vld_d[j] <= vld_d[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				e_d[j]    <= e_d[j-1];
				nlo_d[j]  <= nlo_d[j-1];
				wn_d[j]   <= wn_d[j-1];
				side_d[j] <= side_d[j-1];
				if (ge) begin
					rem_d[j] <= E_W'(r2 - {1'b0, e_d[j-1]});
					q_d[j]   <= q_d[j-1] | (NQ'(1) << BITPOS);
				end else begin
					rem_d[j] <= r2[E_W-1:0];
					q_d[j]   <= q_d[j-1];
				end
			end
		end
	end

	// pick e^|w| or its reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o_s <= 1'b0;
		else if (adv) vld_o_s <= vld_d[NQ];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_s     <= wn_d[NQ] ? {1'b0, q_d[NQ]} : e_d[NQ];
			side_o_s <= side_d[NQ];
		end
	end

	assign vld_out  = vld_o_s;
	assign pw_out   = pw_s;
	assign side_out = side_o_s;

endmodule
`default_nettype wire

// ===== rtl/pressure_to_altitude_isa.sv =====
// Top level: barometric altitude from static pressure, standard atmosphere layers 0 to 6.
//
//  channel   dir   handshake      word
//  sample    in    valid/ready    pressure_pa (17 b, Pa)
//  result    out   valid/ready    altitude_fixed (23 b signed), layer_used (3 b)
//
// One word per cycle is accepted while the output is not stalled; the pipeline holds the 30-stage
// squaring log2, the 40-stage exp series and the 31-stage reciprocal.
// Every stage advances together; a result held at the output with ready low
// freezes the whole pipeline and input ready drops until it is taken.
// Reset (arst_n low) clears only the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_to_altitude_isa_defines.svh"
module pressure_to_altitude_isa #(
	parameter int ALT_FRAC_BITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	p2a_in_if.sink   sample,
	p2a_out_if.source result
);
	import p2a_pkg::*;

	localparam int SH = 16 - ALT_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'd1 << (SH - 1));
	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'd1 << (ALT_W - 1)) - 64'd1);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(64'd1 << (ALT_W - 1)));

	typedef struct packed {
		layer_t layer;
		logic   zero;
	} side_a_t;

	typedef struct packed {
		layer_t      layer;
		logic        zero;
		logic        dneg;
		logic [31:0] tiso;
	} side_b_t;

	logic adv;

	logic              vld_s1;
	logic [PROD_W-1:0] prod_s1;
	side_a_t           sa_s1;
	layer_t            layer_c;

	logic              lg_vld;
	logic [LOG_W-1:0]  lg_val;
	side_a_t           lg_side;

	logic              vld_s2;
	layer_t            layer_s2;
	logic              zero_s2;
	logic              dneg_s2;
	logic [DMAG_W-1:0] dmag_s2;

	logic              vld_s3;
	layer_t            layer_s3;
	logic              zero_s3;
	logic              dneg_s3;
	logic [60:0]       wprod_s3;
	logic [61:0]       iprod_s3;

	logic              vld_s4;
	logic [W_W-1:0]    wmag_s4;
	logic              wneg_s4;
	side_b_t           sb_s4;
	logic [61:0]       wsum_c;
	logic [62:0]       isum_c;
	logic [W_W-1:0]    wclamp_c;

	logic              ex_vld;
	logic [E_W-1:0]    ex_pw;
	side_b_t           ex_side;

	logic              vld_s5;
	side_b_t           sb_s5;
	logic              pneg_s5;
	logic [PM_W-1:0]   pmag_s5;

	logic              vld_s6;
	side_b_t           sb_s6;
	logic              pneg_s6;
	logic [64:0]       kprod_s6;

	logic              vld_s7;
	logic signed [ACC_W-1:0] alt_s7;
	layer_t            layer_s7;
	logic signed [ACC_W-1:0] base_c;
	logic [65:0]       ksum_c;
	logic signed [ACC_W-1:0] tl_c;
	logic signed [ACC_W-1:0] ti_c;
	logic signed [ACC_W-1:0] alt_c;

	logic              vld_s8;
	altitude_t         alt_s8;
	layer_t            layer_s8;
	logic signed [ACC_W-1:0] rsh_c;
	altitude_t         sat_c;

	// whole pipeline moves when the output register is free or being taken
	assign adv          = !vld_s8 || result.ready;
	assign sample.ready = adv;

	// layer pick
	always_comb begin
		if (sample.pressure_pa <= FLOOR6) layer_c = LAYER6;
		else if (sample.pressure_pa <= FLOOR5) layer_c = LAYER5;
		else if (sample.pressure_pa <= FLOOR4) layer_c = LAYER4;
		else if (sample.pressure_pa <= FLOOR3) layer_c = LAYER3;
		else if (sample.pressure_pa <= FLOOR2) layer_c = LAYER2;
		else if (sample.pressure_pa <= FLOOR1) layer_c = LAYER1;
		else layer_c = LAYER0;
	end

	// stage 1: scale pressure by 1e5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1     <= PROD_W'(sample.pressure_pa) * PROD_W'(100000);
			sa_s1.layer <= layer_c;
			sa_s1.zero  <= (sample.pressure_pa == '0);
		end
	end

	p2a_log2 #(
		.SIDE_W ($bits(side_a_t))
	) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s1),
		.val_in   (prod_s1),
		.side_in  (sa_s1),
		.vld_out  (lg_vld),
		.log_out  (lg_val),
		.side_out (lg_side)
	);

	// stage 2: log2 of the pressure ratio
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= lg_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			layer_s2 <= lg_side.layer;
			zero_s2  <= lg_side.zero;
			if (lg_side.zero) begin
				dneg_s2 <= 1'b0;
				dmag_s2 <= '0;
			end else if (lg_val < LP_Q30[lg_side.layer]) begin
				dneg_s2 <= 1'b1;
				dmag_s2 <= DMAG_W'(LP_Q30[lg_side.layer] - lg_val);
			end else begin
				dneg_s2 <= 1'b0;
				dmag_s2 <= DMAG_W'(lg_val - LP_Q30[lg_side.layer]);
			end
		end
	end

	// stage 3: exponent and isothermal products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			layer_s3 <= layer_s2;
			zero_s3  <= zero_s2;
			dneg_s3  <= dneg_s2;
			wprod_s3 <= 61'(CMAG[layer_s2]) * 61'(dmag_s2);
			iprod_s3 <= 62'(A16[layer_s2]) * 62'(dmag_s2);
		end
	end

	// stage 4: round to Q30, clamp the exponent at 1.0
	assign wsum_c = {1'b0, wprod_s3} + 62'(HALF_Q30);
	assign isum_c = {1'b0, iprod_s3} + 63'(HALF_Q30);
	assign wclamp_c = (wsum_c[61:30] > 32'(ONE_Q30)) ? W_W'(ONE_Q30) : wsum_c[30+W_W-1:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wmag_s4    <= wclamp_c;
			wneg_s4    <= LAPSE_NEG[layer_s3] ? dneg_s3 : !dneg_s3;
			sb_s4.layer <= layer_s3;
			sb_s4.zero  <= zero_s3;
			sb_s4.dneg  <= dneg_s3;
			sb_s4.tiso  <= isum_c[61:30];
		end
	end

	p2a_exp #(
		.SIDE_W ($bits(side_b_t))
	) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s4),
		.w_in     (wmag_s4),
		.wneg_in  (wneg_s4),
		.side_in  (sb_s4),
		.vld_out  (ex_vld),
		.pw_out   (ex_pw),
		.side_out (ex_side)
	);

	// stage 5: power term minus one, as sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= ex_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s5 <= ex_side;
			if (ex_side.zero) begin
				pneg_s5 <= 1'b1;
				pmag_s5 <= PM_W'(ONE_Q30);
			end else if (ex_pw >= E_W'(ONE_Q30)) begin
				pneg_s5 <= 1'b0;
				pmag_s5 <= PM_W'(ex_pw - E_W'(ONE_Q30));
			end else begin
				pneg_s5 <= 1'b1;
				pmag_s5 <= PM_W'(E_W'(ONE_Q30) - ex_pw);
			end
		end
	end

	// stage 6: scale by T/|L|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s6    <= sb_s5;
			pneg_s6  <= pneg_s5;
			kprod_s6 <= 65'(KMAG[sb_s5.layer]) * 65'(pmag_s5);
		end
	end

	// stage 7: add to or subtract from the layer base altitude, Q16
	assign base_c = $signed({7'b0, BASE_H_M[sb_s6.layer], 16'b0});
	assign ksum_c = {1'b0, kprod_s6} + 66'(HALF_Q30);
	assign tl_c   = $signed({4'b0, ksum_c[65:30]});
	assign ti_c   = $signed({8'b0, sb_s6.tiso});

	always_comb begin
		if (LAYER_ISO[sb_s6.layer]) begin
			alt_c = sb_s6.dneg ? (base_c + ti_c) : (base_c - ti_c);
		end else begin
			alt_c = (LAPSE_NEG[sb_s6.layer] == pneg_s6) ? (base_c + tl_c) : (base_c - tl_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alt_s7   <= alt_c;
			layer_s7 <= sb_s6.layer;
		end
	end

	// stage 8: round to the output fraction and saturate
	assign rsh_c = (alt_s7 + RND) >>> SH;

	always_comb begin
		if (rsh_c > OUT_MAX) sat_c = OUT_MAX[ALT_W-1:0];
		else if (rsh_c < OUT_MIN) sat_c = OUT_MIN[ALT_W-1:0];
		else sat_c = rsh_c[ALT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (adv) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alt_s8   <= sat_c;
			layer_s8 <= layer_s7;
		end
	end

	assign result.valid          = vld_s8;
	assign result.altitude_fixed = alt_s8;
	assign result.layer_used     = layer_s8;

	`P2A_ASSERT_IMP(a_layer_range, clk, arst_n, result.valid, result.layer_used <= LAYER6, "layer out of range")
	`P2A_ASSERT_IMP(a_upper_positive, clk, arst_n, result.valid && result.layer_used != LAYER0, !result.altitude_fixed[ALT_W-1], "negative altitude above layer 0")
	`P2A_ASSERT_NXT(a_stall_freeze, clk, arst_n, !adv, $stable(vld_s7) && $stable(alt_s7), "pipeline moved during stall")

endmodule
`default_nettype wire

// ===== tb/tb_pressure_to_altitude_isa.sv =====
// Testbench for pressure_to_altitude_isa: layer edges, random samples, output backpressure.
`timescale 1ns / 1ps
module tb_pressure_to_altitude_isa;
	import p2a_pkg::*;

	localparam int FRAC = 4;

	logic clk;
	logic arst_n;
	p2a_in_if  sample_ch();
	p2a_out_if result_ch();

	pressure_to_altitude_isa #(.ALT_FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	// expected altitude/layer pairs, oldest first
	typedef struct packed {
		altitude_t altitude;
		layer_t    layer;
	} altitude_word_t;

	altitude_word_t pending_altitudes[$];
	int  errors;
	bit  no_idle;      // both sides run without gaps
	int  hold_cycles;  // one-off long receiver stall request

	// standard atmosphere tables, layers 0..6
	localparam longint LYR_H_M [NLAYER] = '{0, 11000, 20000, 32000, 47000, 51000, 71000};
	localparam logic [63:0] LYR_P_E5 [NLAYER] = '{64'd10132500000, 64'd2263200000,
		64'd547489000, 64'd86801900, 64'd11090600, 64'd6693880, 64'd395642};
	localparam int LYR_LAPSE_DK [NLAYER] = '{-65, 0, 10, 28, 0, -28, -20};
	localparam logic [63:0] LYR_T_CK [NLAYER] = '{64'd28815, 64'd21665, 64'd21665,
		64'd22865, 64'd27065, 64'd27065, 64'd21465};
	localparam logic [63:0] R_MILLI = 64'd287053;
	localparam logic [63:0] G0_E5   = 64'd980665;
	localparam logic [63:0] LN2_FIX = 64'd744261118;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// log2 with a 30-bit fraction, truncating squarer
	function automatic logic [63:0] log2_fix(input logic [63:0] v);
		logic [63:0] y;
		logic [63:0] r;
		int msb;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) msb = i;
		y = (msb >= 30) ? (v >> (msb - 30)) : (v << (30 - msb));
		r = 64'(msb) << 30;
		for (int b = 29; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	// exp(w), w in [0, 1.0], 20-term series
	function automatic logic [63:0] exp_fix(input logic [63:0] w);
		logic [63:0] sum;
		logic [63:0] term;
		sum = ONE_Q30;
		term = ONE_Q30;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * w) >> 30) / 64'(k);
			sum += term;
		end
		return sum;
	endfunction

	function automatic altitude_word_t predict_altitude(input pressure_t p);
		altitude_word_t res;
		layer_t ly;
		logic [63:0] dmag, den, a16, cmag, kmag, lmag, wmag, e, pw, pmag, t;
		logic [63:0] lx, lp;
		longint alt, pm1, v;
		bit dneg, wneg, pneg;
		int lt;
		ly = LAYER0;
		if (p <= FLOOR1) ly = LAYER1;
		if (p <= FLOOR2) ly = LAYER2;
		if (p <= FLOOR3) ly = LAYER3;
		if (p <= FLOOR4) ly = LAYER4;
		if (p <= FLOOR5) ly = LAYER5;
		if (p <= FLOOR6) ly = LAYER6;
		alt = LYR_H_M[ly] * 65536;
		lt = LYR_LAPSE_DK[ly];
		dmag = 0;
		dneg = 0;
		if (p != 0) begin
			lx = log2_fix(64'(p) * 64'd100000);
			lp = log2_fix(LYR_P_E5[ly]);
			dneg = lx < lp;
			dmag = dneg ? lp - lx : lx - lp;
		end
		if (lt == 0) begin
			// isothermal: logarithmic form
			den = G0_E5 << 14;
			a16 = (R_MILLI * LYR_T_CK[ly] * LN2_FIX + den / 2) / den;
			t = (a16 * dmag + HALF_Q30) >> 30;
			alt = dneg ? alt + longint'(t) : alt - longint'(t);
		end else begin
			// lapse layer: power form
			lmag = 64'(lt < 0 ? -lt : lt);
			den = 64'd100 * G0_E5;
			cmag = (lmag * R_MILLI * LN2_FIX + den / 2) / den;
			kmag = (LYR_T_CK[ly] * 64'd100 * 64'd65536 + lmag / 2) / lmag;
			if (p == 0) begin
				pm1 = -longint'(ONE_Q30);
			end else begin
				wmag = (cmag * dmag + HALF_Q30) >> 30;
				wneg = (lt < 0) ? dneg : !dneg;
				if (wmag > ONE_Q30) wmag = ONE_Q30;
				e = exp_fix(wmag);
				pw = wneg ? (((64'd1 << 60) + e / 2) / e) : e;
				pm1 = longint'(pw) - longint'(ONE_Q30);
			end
			pneg = pm1 < 0;
			pmag = 64'(pneg ? -pm1 : pm1);
			t = (kmag * pmag + HALF_Q30) >> 30;
			if ((lt < 0) == pneg) alt += longint'(t);
			else alt -= longint'(t);
		end
		// round to FRAC fraction bits, saturate
		v = (alt + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
		if (v > (longint'(1) << 22) - 1) v = (longint'(1) << 22) - 1;
		if (v < -(longint'(1) << 22)) v = -(longint'(1) << 22);
		res.altitude = altitude_t'(v);
		res.layer = ly;
		return res;
	endfunction

	// offer one pressure word, wait for acceptance
	task automatic send_pressure(input pressure_t p);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pressure_pa <= p;
		do @(posedge clk); while (!sample_ch.ready);
		pending_altitudes.push_back(predict_altitude(p));
	endtask

	// result receiver and checker
	initial begin
		int stall;
		altitude_word_t want;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 5);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (pending_altitudes.size() == 0) begin
				$display("%0t: unexpected result alt=%0d layer=%0d", $time,
					result_ch.altitude_fixed, result_ch.layer_used);
				errors++;
			end else begin
				want = pending_altitudes.pop_front();
				if (result_ch.altitude_fixed !== want.altitude) begin
					$display("%0t: altitude expected %0d actual %0d", $time,
						want.altitude, result_ch.altitude_fixed);
					errors++;
				end
				if (result_ch.layer_used !== want.layer) begin
					$display("%0t: layer expected %0d actual %0d", $time,
						want.layer, result_ch.layer_used);
					errors++;
				end
			end
		end
	end

	// layer thresholds, zero pressure, extremes
	task automatic test_layer_edges();
		pressure_t edges[$];
		edges = '{0, 1, 2, FLOOR6, 4, 65, FLOOR5, 67, 109, FLOOR4, 111, 867, FLOOR3,
			869, 5473, FLOOR2, 5475, 22631, FLOOR1, 22633, 101325, 101326, 65536,
			65535, 131071};
		foreach (edges[i]) send_pressure(edges[i]);
	endtask

	// random pressures, spread over all layers
	task automatic test_random_samples(input int count);
		pressure_t p;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 2) && (i < count / 2 + 60);
			case ($urandom_range(0, 7))
				0: p = pressure_t'($urandom_range(0, FLOOR5));
				1: p = pressure_t'($urandom_range(FLOOR5, FLOOR4));
				2: p = pressure_t'($urandom_range(FLOOR4, FLOOR3));
				3: p = pressure_t'($urandom_range(FLOOR3, FLOOR2));
				4: p = pressure_t'($urandom_range(FLOOR2, FLOOR1));
				5: p = pressure_t'($urandom_range(FLOOR1, 110000));
				default: p = pressure_t'($urandom_range(0, 131071));
			endcase
			send_pressure(p);
		end
		no_idle = 0;
	endtask

	// long receiver hold while the sender keeps offering words
	task automatic test_output_backpressure();
		hold_cycles = 300;
		no_idle = 1;
		for (int i = 0; i < 200; i++) send_pressure(pressure_t'($urandom_range(0, 131071)));
		no_idle = 0;
	endtask

	initial begin
		errors = 0;
		no_idle = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.pressure_pa = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_layer_edges();
		test_output_backpressure();
		test_random_samples(430);
		sample_ch.valid <= 1'b0;
		while (pending_altitudes.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

endmodule
